// ===== design/cle_pkg.sv =====
package cle_pkg;

   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_ESC    = 8'h1B;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TILDE  = 8'h7E;

   localparam logic DEST_ECHO = 1'b0;
   localparam logic DEST_CMD  = 1'b1;

   typedef enum logic [1:0] {
      KIND_APPEND,
      KIND_ERASE,
      KIND_ABANDON,
      KIND_ENTER
   } cle_kind_type;

   typedef struct packed {
      cle_kind_type kind;
      logic [7:0]   ch;
   } cle_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMD,
      ST_DOLLAR,
      ST_SPACE,
      ST_ERASE_SPACE,
      ST_ERASE_BACK
   } cle_state_type;

endpackage

// ===== design/cle_front.sv =====
module cle_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_rx_byte,
   input  logic                csr_write_en,
   input  logic                csr_write_data,
   output logic                push_valid,
   output cle_pkg::cle_op_type push_op,
   input  logic                queue_full
);
   import cle_pkg::*;

   logic sink_present_ff;
   logic sink_present_in;
   logic keep;

   assign sink_present_in = csr_write_en ? csr_write_data : sink_present_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sink_present_ff <= 1'b1;
      end else begin
         sink_present_ff <= sink_present_in;
      end
   end

   // classify: drop bytes that cause nothing whatever the line holds
   always_comb begin
      keep         = 1'b0;
      push_op.kind = KIND_APPEND;
      push_op.ch   = req_rx_byte;
      priority if (req_rx_byte == CH_CR) begin
         keep         = sink_present_ff;
         push_op.kind = KIND_ENTER;
      end else if (req_rx_byte == CH_BS) begin
         keep         = 1'b1;
         push_op.kind = KIND_ERASE;
      end else if (req_rx_byte == CH_ESC) begin
         keep         = 1'b1;
         push_op.kind = KIND_ABANDON;
      end else if (req_rx_byte >= CH_SPACE && req_rx_byte <= CH_TILDE) begin
         keep         = 1'b1;
         push_op.kind = KIND_APPEND;
      end else begin
         keep         = 1'b0;
      end
   end

   assign req_ready  = !queue_full;
   assign push_valid = req_valid && !queue_full && keep;

endmodule

// ===== design/cle_queue.sv =====
module cle_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  cle_pkg::cle_op_type push_op,
   output logic                queue_full,
   input  logic                pop,
   output logic                pop_valid,
   output cle_pkg::cle_op_type pop_op
);
   import cle_pkg::*;

   cle_op_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign queue_full = (count_ff == 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_op     = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !queue_full;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== design/cle_back.sv =====
module cle_back #(
   parameter int LINE_BYTES = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                op_valid,
   input  cle_pkg::cle_op_type op,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_dest,
   output logic [7:0]          rsp_data,
   output logic                rsp_cmd_end,
   output logic                rsp_last
);
   import cle_pkg::*;

   localparam int LEN_W = $clog2(LINE_BYTES);

   cle_state_type state_ff, state_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] idx_ff, idx_in;
   logic [7:0]       line_mem [LINE_BYTES];
   logic [7:0]       rd_data_ff;
   logic             mem_we;
   logic             rd_en;
   logic [LEN_W-1:0] rd_addr;

   logic             out_free;
   logic             emit;
   logic             emit_dest;
   logic [7:0]       emit_data;
   logic             emit_end;
   logic             emit_last;
   logic             has_room;
   logic             at_end;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_dest_ff;
   logic [7:0]       rsp_data_ff;
   logic             rsp_cmd_end_ff;
   logic             rsp_last_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign has_room = (len_ff != LEN_W'(LINE_BYTES - 1));
   assign at_end   = ((idx_ff + LEN_W'(1)) == len_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (op_valid && out_free) begin
               unique case (op.kind)
                  KIND_APPEND:  state_in = ST_IDLE;
                  KIND_ERASE:   state_in = (len_ff != '0) ? ST_ERASE_SPACE : ST_IDLE;
                  KIND_ABANDON: state_in = ST_DOLLAR;
                  KIND_ENTER:   state_in = (len_ff != '0) ? ST_CMD : ST_DOLLAR;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_CMD: begin
            if (out_free && at_end) begin
               state_in = ST_DOLLAR;
            end
         end
         ST_DOLLAR: begin
            if (out_free) begin
               state_in = ST_SPACE;
            end
         end
         ST_SPACE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_ERASE_SPACE: begin
            if (out_free) begin
               state_in = ST_ERASE_BACK;
            end
         end
         ST_ERASE_BACK: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop       = 1'b0;
      emit      = 1'b0;
      emit_dest = DEST_ECHO;
      emit_data = CH_SPACE;
      emit_end  = 1'b0;
      emit_last = 1'b0;
      len_in    = len_ff;
      idx_in    = idx_ff;
      mem_we    = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            pop = op_valid && out_free;
            if (pop) begin
               unique case (op.kind)
                  KIND_APPEND: begin
                     if (has_room) begin
                        mem_we    = 1'b1;
                        len_in    = len_ff + LEN_W'(1);
                        emit      = 1'b1;
                        emit_data = op.ch;
                        emit_last = 1'b1;
                     end
                  end
                  KIND_ERASE: begin
                     if (len_ff != '0) begin
                        len_in    = len_ff - LEN_W'(1);
                        emit      = 1'b1;
                        emit_data = CH_BS;
                     end
                  end
                  KIND_ABANDON: begin
                     emit      = 1'b1;
                     emit_data = CH_LF;
                  end
                  KIND_ENTER: begin
                     emit      = 1'b1;
                     emit_data = CH_LF;
                     idx_in    = '0;
                     rd_en     = 1'b1;
                     rd_addr   = '0;
                  end
                  default: begin
                     emit = 1'b0;
                  end
               endcase
            end
         end
         ST_CMD: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_dest = DEST_CMD;
               emit_data = rd_data_ff;
               emit_end  = at_end;
               if (!at_end) begin
                  idx_in  = idx_ff + LEN_W'(1);
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + LEN_W'(1);
               end
            end
         end
         ST_DOLLAR: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_data = CH_DOLLAR;
               len_in    = '0;
            end
         end
         ST_SPACE: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_data = CH_SPACE;
               emit_last = 1'b1;
            end
         end
         ST_ERASE_SPACE: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_data = CH_SPACE;
            end
         end
         ST_ERASE_BACK: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_data = CH_BS;
               emit_last = 1'b1;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_dest_ff    <= emit_dest;
         rsp_data_ff    <= emit_data;
         rsp_cmd_end_ff <= emit_end;
         rsp_last_ff    <= emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[len_ff] <= op.ch;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_dest    = rsp_dest_ff;
   assign rsp_data    = rsp_data_ff;
   assign rsp_cmd_end = rsp_cmd_end_ff;
   assign rsp_last    = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(LINE_BYTES - 1))
      else $error("line length beyond capacity");

   a_cmd_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CMD |-> len_ff != '0 && idx_ff < len_ff)
      else $error("command dispatch on empty line or past its end");

   a_end_is_cmd: assert property (@(posedge clock) disable iff (reset)
      emit && emit_end |-> emit_dest == DEST_CMD && !emit_last)
      else $error("end mark on an echo byte");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      emit && emit_last |=> state_ff == ST_IDLE)
      else $error("final result emitted before sequence done");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> state_ff == ST_IDLE && out_free)
      else $error("item taken while busy");
`endif

endmodule

// ===== design/command_line_editor.sv =====
// Terminal line editor: one received byte in, zero or more result bytes out.
// req_* carries received bytes (valid/ready); rsp_* carries results, each
// tagged as terminal echo or command byte, with rsp_cmd_end on the final
// byte of a dispatched line and rsp_last on the final result of one byte.
// csr_write_en/csr_write_data set sink_present; write only while idle.
// The front end classifies bytes and drops ignored ones at once; kept bytes
// wait in a two-entry queue in front of the back-end sequencer.
// The first result of an accepted byte passes through the queue and the
// output register. The sequencer emits one result per cycle while rsp_ready
// is high: printable byte 1 result (0 when the line is full), backspace 3
// (0 on an empty line), escape 3, carriage return with a line of N bytes
// N+3 results, at most LINE_BYTES+2 per byte (34 at the default size).
// Reset: empty line, sink_present set, no prompt sent, queue and output
// register empty. No clearing pass is needed.
// When the receiver stalls, the output register holds its result, the
// sequencer waits, and the queue fills; req_ready drops once it is full.
module command_line_editor #(
   parameter int LINE_BYTES = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_dest,
   output logic [7:0] rsp_data,
   output logic       rsp_cmd_end,
   output logic       rsp_last,
   input  logic       csr_write_en,
   input  logic       csr_write_data
);
   import cle_pkg::*;

   logic       push_valid;
   cle_op_type push_op;
   logic       queue_full;
   logic       pop;
   logic       pop_valid;
   cle_op_type pop_op;

   cle_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .push_valid     (push_valid),
      .push_op        (push_op),
      .queue_full     (queue_full)
   );

   cle_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .queue_full (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_op     (pop_op)
   );

   cle_back #(
      .LINE_BYTES (LINE_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .op_valid    (pop_valid),
      .op          (pop_op),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_dest    (rsp_dest),
      .rsp_data    (rsp_data),
      .rsp_cmd_end (rsp_cmd_end),
      .rsp_last    (rsp_last)
   );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import cle_pkg::*;

   localparam int LINE_BYTES = 32;
   localparam int SETTLE_CYCLES = LINE_BYTES + 8;

   typedef struct packed {
      logic       dest;
      logic [7:0] data;
      logic       cmd_end;
      logic       last;
   } editor_result_type;

   class line_editor_scoreboard;
      logic [7:0]        line_bytes[LINE_BYTES];
      int unsigned       line_len;
      bit                sink_on;
      editor_result_type awaited[$];
      editor_result_type fresh[$];
      int                errors;

      function new();
         line_len = 0;
         sink_on  = 1'b1;
         errors   = 0;
      endfunction

      function void set_sink(bit value);
         sink_on = value;
      endfunction

      function void add(logic dest, logic [7:0] data, logic cmd_end);
         editor_result_type r;
         r.dest    = dest;
         r.data    = data;
         r.cmd_end = cmd_end;
         r.last    = 1'b0;
         fresh.push_back(r);
      endfunction

      function void note_byte(logic [7:0] b);
         editor_result_type r;
         fresh.delete();
         if (b == CH_CR) begin
            if (sink_on) begin
               add(DEST_ECHO, CH_LF, 1'b0);
               for (int i = 0; i < line_len; i++)
                  add(DEST_CMD, line_bytes[i], (i + 1 == line_len));
               add(DEST_ECHO, CH_DOLLAR, 1'b0);
               add(DEST_ECHO, CH_SPACE, 1'b0);
               line_len = 0;
            end
         end else if (b == CH_BS) begin
            if (line_len > 0) begin
               line_len--;
               add(DEST_ECHO, CH_BS, 1'b0);
               add(DEST_ECHO, CH_SPACE, 1'b0);
               add(DEST_ECHO, CH_BS, 1'b0);
            end
         end else if (b == CH_ESC) begin
            add(DEST_ECHO, CH_LF, 1'b0);
            add(DEST_ECHO, CH_DOLLAR, 1'b0);
            add(DEST_ECHO, CH_SPACE, 1'b0);
            line_len = 0;
         end else if (b >= CH_SPACE && b <= CH_TILDE) begin
            if (line_len + 1 < LINE_BYTES) begin
               line_bytes[line_len] = b;
               line_len++;
               add(DEST_ECHO, b, 1'b0);
            end
         end
         for (int i = 0; i < fresh.size(); i++) begin
            r = fresh[i];
            r.last = (i == fresh.size() - 1);
            awaited.push_back(r);
         end
      endfunction

      function void check_result(logic dest, logic [7:0] data, logic cmd_end, logic last);
         editor_result_type want;
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t: unexpected result dest=%0d data=%02h cmd_end=%0d last=%0d",
                     $time, dest, data, cmd_end, last);
            return;
         end
         want = awaited.pop_front();
         if (dest !== want.dest) begin
            errors++;
            $display("%0t: dest mismatch: expected %0d, got %0d", $time, want.dest, dest);
         end
         if (data !== want.data) begin
            errors++;
            $display("%0t: data mismatch: expected %02h, got %02h", $time, want.data, data);
         end
         if (cmd_end !== want.cmd_end) begin
            errors++;
            $display("%0t: cmd_end mismatch: expected %0d, got %0d",
                     $time, want.cmd_end, cmd_end);
         end
         if (last !== want.last) begin
            errors++;
            $display("%0t: last mismatch: expected %0d, got %0d", $time, want.last, last);
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_dest;
   logic [7:0] rsp_data;
   logic       rsp_cmd_end;
   logic       rsp_last;
   logic       csr_write_en = 1'b0;
   logic       csr_write_data = 1'b0;

   line_editor_scoreboard sb = new();

   int burst_left = 0;
   int kept_count = 0;
   int stall_mode = 0;
   int mode_left = 0;
   int stall_tick = 0;

   command_line_editor #(
      .LINE_BYTES(LINE_BYTES)
   ) u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_dest      (rsp_dest),
      .rsp_data      (rsp_data),
      .rsp_cmd_end   (rsp_cmd_end),
      .rsp_last      (rsp_last),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(5, 60);
      end
      mode_left--;
      stall_tick++;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= (stall_tick % 4 == 0);
         default: rsp_ready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_dest, rsp_data, rsp_cmd_end, rsp_last);
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_byte(b);
      if (b == CH_CR || b == CH_BS || b == CH_ESC || (b >= CH_SPACE && b <= CH_TILDE))
         kept_count++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_sink(input bit value);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      sb.set_sink(value);
   endtask

   task automatic send_line(input int n, input bit enter);
      int pick;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8)
            send_byte(CH_BS);
         else if (pick < 12)
            send_byte(8'($urandom_range(0, 255)));
         else
            send_byte(8'($urandom_range(CH_SPACE, CH_TILDE)));
      end
      send_byte(enter ? CH_CR : CH_ESC);
   endtask

   task automatic random_phase(input int target);
      int start_count;
      int len;
      start_count = kept_count;
      while (kept_count - start_count < target) begin
         case ($urandom_range(0, 9))
            0: send_byte(8'($urandom_range(0, 255)));
            1: send_byte(8'($urandom_range(128, 255)));
            2: send_line(int'($urandom_range(25, 40)), $urandom_range(0, 3) != 0);
            default: begin
               len = $urandom_range(0, 12);
               send_line(len, $urandom_range(0, 3) != 0);
            end
         endcase
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_sink(1'b1);
      send_byte(CH_SPACE);
      send_byte(CH_TILDE);
      send_byte(8'h1F);
      send_byte(8'h7F);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(CH_LF);
      send_byte(CH_BS);
      send_byte(CH_BS);
      send_byte(CH_BS);
      send_byte(CH_CR);
      send_byte("A");
      send_byte("b");
      send_byte(CH_CR);
      send_byte("x");
      send_byte(CH_ESC);
      send_byte(CH_ESC);
      random_phase(80);
      drain();

      write_sink(1'b0);
      send_byte("q");
      send_byte(CH_CR);
      send_byte(CH_ESC);
      random_phase(80);
      drain();

      write_sink(1'b1);
      random_phase(80);
      drain();

      write_sink(1'b0);
      random_phase(80);
      drain();

      write_sink(1'b1);
      random_phase(70);
      drain();

      if (sb.errors == 0 && sb.awaited.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
